// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the tree diameter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tdb_pkg.sv =====
`default_nettype none
package tdb_pkg;
  localparam int MaxNodes = 1024;
  localparam int MaxSlots = 2048;
  localparam int NodeW = 11;
  localparam int SlotW = 12;
  localparam int ValW = 21;

  // input item modes
  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAdd = 2'd1;
  localparam logic [1:0] ModeCompute = 2'd2;
  localparam logic [1:0] ModeQuery = 2'd3;

  // result kinds
  localparam logic KindDiameter = 1'b0;
  localparam logic KindQuery = 1'b1;

  // register addresses
  localparam logic [1:0] RegNodeCount = 2'd0;
endpackage
`default_nettype wire

// ===== hw/rtl/tree_diameter_double_bfs.sv =====
`default_nettype none
// Tree diameter engine. Edges are loaded one per start pulse (mode 1) into
// adjacency lists held in on-chip memories; mode 0 clears the graph, mode 2
// runs two breadth-first passes and returns the diameter, mode 3 returns the
// walk length for a visit count from the stored diameter. busy is high while
// an item is at work; a result is shown for exactly one cycle under done and
// cannot be held off. Clear sweeps the head memory. Each compute pass first
// clears the mark memory, then walks the queue through each node's adjacency
// slots, then scans the nodes for the farthest one. After reset the head
// memory is swept once before the first item is taken.
module tree_diameter_double_bfs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [10:0] node_a,
  input  wire logic [10:0] node_b,
  input  wire logic [20:0] visit_count,
  output logic             done,
  output logic             result_kind,
  output logic [20:0]      result_value
);
  `include "assert_macros.svh"

  localparam int NW = tdb_pkg::NodeW;
  localparam int SW = tdb_pkg::SlotW;
  localparam logic [SW-1:0] Empty = SW'(tdb_pkg::MaxSlots);
  localparam logic [NW-1:0] LastNode = NW'(tdb_pkg::MaxNodes);

  typedef enum logic [15:0] {
    S_INIT   = 16'h0001,
    S_IDLE   = 16'h0002,
    S_ADD1   = 16'h0004,
    S_ADD2   = 16'h0008,
    S_QUERY  = 16'h0010,
    S_MCLR   = 16'h0020,
    S_POP    = 16'h0040,
    S_HEAD   = 16'h0080,
    S_SLOT   = 16'h0100,
    S_MARK   = 16'h0200,
    S_SCAN   = 16'h0400,
    S_SCANW  = 16'h0800,
    S_DONE   = 16'h1000,
    S_POPW   = 16'h2000,
    S_SLOTW  = 16'h4000,
    S_MARKW  = 16'h8000
  } state_t;

  state_t state;

  // config register
  logic [NW-1:0] node_count;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NW'(1);
    end else if (psel && penable && pwrite && paddr == tdb_pkg::RegNodeCount) begin
      node_count <= pwdata[NW-1:0];
    end
  end
  assign prdata = (paddr == tdb_pkg::RegNodeCount) ? {{(32-NW){1'b0}}, node_count} : '0;

  // memories
  logic [SW-1:0] head_mem [tdb_pkg::MaxNodes+1];
  logic [SW-1:0] next_mem [tdb_pkg::MaxSlots];
  logic [NW-1:0] tgt_mem [tdb_pkg::MaxSlots];
  logic [NW:0]   dist_mem [tdb_pkg::MaxNodes+1]; // msb is the visited mark
  logic [NW-1:0] queue_mem [tdb_pkg::MaxNodes];

  logic [SW-1:0] head_q, next_q;
  logic [NW-1:0] tgt_q, queue_q;
  logic [NW:0]   dist_q;

  logic          head_we;
  logic [NW-1:0] head_wa, head_ra;
  logic [SW-1:0] head_wd;
  logic          edge_we;
  logic [SW-1:0] edge_wa, edge_ra;
  logic [SW-1:0] next_wd;
  logic [NW-1:0] tgt_wd;
  logic          dist_we;
  logic [NW-1:0] dist_wa, dist_ra;
  logic [NW:0]   dist_wd;
  logic          queue_we;
  logic [NW-1:0] queue_wa, queue_ra;
  logic [NW-1:0] queue_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (edge_we) begin
      next_mem[edge_wa[SW-2:0]] <= next_wd;
      tgt_mem[edge_wa[SW-2:0]] <= tgt_wd;
    end
    next_q <= next_mem[edge_ra[SW-2:0]];
    tgt_q <= tgt_mem[edge_ra[SW-2:0]];
  end
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_q <= dist_mem[dist_ra];
  end
  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa[NW-2:0]] <= queue_wd;
    queue_q <= queue_mem[queue_ra[NW-2:0]];
  end

  // control registers
  logic [SW-1:0] edge_total;
  logic [NW-1:0] diameter;
  logic [NW-1:0] ia, ib, cnt;
  logic [NW-1:0] rd_ptr, wr_ptr;
  logic [NW-1:0] cur;
  logic [NW-1:0] cur_dist;
  logic [SW-1:0] slot;
  logic [NW-1:0] best, far;
  logic          pass2;
  logic [NW-1:0] lim;
  logic [NW:0]   wr_cnt;

  assign lim = (node_count > LastNode) ? LastNode : node_count;

  logic [20:0] q_answer;
  tdb_query u_query (.clk(clk), .visit_count(visit_count), .diameter(diameter),
                     .answer(q_answer));

  assign busy = (state != S_IDLE);

  logic addr_ok;
  assign addr_ok = (node_a >= NW'(1)) && (node_a <= LastNode) && (node_b >= NW'(1)) &&
                   (node_b <= LastNode) && (edge_total <= Empty - SW'(2));

  // memory port drive
  always_comb begin
    head_we = 1'b0; head_wa = cnt; head_wd = Empty; head_ra = cur;
    edge_we = 1'b0; edge_wa = edge_total; next_wd = head_q; tgt_wd = ib;
    edge_ra = slot;
    dist_we = 1'b0; dist_wa = cnt; dist_wd = '0; dist_ra = cnt;
    queue_we = 1'b0; queue_wa = wr_ptr; queue_wd = tgt_q; queue_ra = rd_ptr;
    case (state)
      S_INIT: head_we = 1'b1;
      S_IDLE: begin
        head_ra = node_a;
      end
      S_ADD1: begin
        head_ra = ib;
        edge_we = 1'b1; tgt_wd = ib;
        head_we = 1'b1; head_wa = ia; head_wd = edge_total;
      end
      S_ADD2: begin
        edge_we = 1'b1; tgt_wd = ia;
        // self loop: the head read raced the write of the previous cycle
        if (ia == ib) next_wd = edge_total - SW'(1);
        head_we = 1'b1; head_wa = ib; head_wd = edge_total;
      end
      S_MCLR: begin
        dist_we = 1'b1;
      end
      S_MARKW: begin
        dist_we = 1'b1; dist_wa = cur; dist_wd = {1'b1, {NW{1'b0}}};
        queue_we = 1'b1; queue_wa = '0; queue_wd = cur;
      end
      S_POPW: head_ra = queue_q;
      S_HEAD: begin
        head_ra = cur;
        dist_ra = cur;
      end
      S_SLOTW: dist_ra = tgt_q;
      S_MARK: begin
        if (!dist_q[NW] && tgt_q <= LastNode && wr_cnt < (NW+1)'(tdb_pkg::MaxNodes)) begin
          dist_we = 1'b1; dist_wa = tgt_q; dist_wd = {1'b1, cur_dist + NW'(1)};
          queue_we = 1'b1; queue_wa = wr_ptr; queue_wd = tgt_q;
        end
      end
      S_SCAN: dist_ra = cnt;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      edge_total <= '0;
      diameter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          cnt <= cnt + NW'(1);
          if (cnt == LastNode) begin
            state <= S_IDLE;
            edge_total <= '0;
            diameter <= '0;
          end
        end
        S_IDLE: begin
          if (start) begin
            ia <= node_a; ib <= node_b; cnt <= '0;
            case (mode)
              tdb_pkg::ModeClear: state <= S_INIT;
              tdb_pkg::ModeAdd: state <= addr_ok ? S_ADD1 : S_IDLE;
              tdb_pkg::ModeCompute: begin
                pass2 <= 1'b0; cur <= NW'(1); state <= S_MCLR;
              end
              tdb_pkg::ModeQuery: state <= S_QUERY;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ADD1: begin
          edge_total <= edge_total + SW'(1);
          state <= S_ADD2;
        end
        S_ADD2: begin
          edge_total <= edge_total + SW'(1);
          state <= S_IDLE;
        end
        S_QUERY: begin
          done <= 1'b1; result_kind <= tdb_pkg::KindQuery; result_value <= q_answer;
          state <= S_IDLE;
        end
        S_MCLR: begin
          cnt <= cnt + NW'(1);
          if (cnt == LastNode) state <= S_MARKW;
        end
        S_MARKW: begin
          rd_ptr <= '0; wr_ptr <= NW'(1); wr_cnt <= (NW+1)'(1);
          state <= S_POP;
        end
        S_POP: begin
          if ({1'b0, rd_ptr} == wr_cnt) begin
            cnt <= NW'(1); best <= '0; far <= NW'(1);
            state <= S_SCAN;
          end else begin
            rd_ptr <= rd_ptr + NW'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          cur <= queue_q;
          state <= S_HEAD;
        end
        S_HEAD: begin
          // head_q and dist_q for cur valid next cycle
          state <= S_SLOT;
          slot <= Empty;
        end
        S_SLOT: begin
          if (slot == Empty) begin
            slot <= head_q; cur_dist <= dist_q[NW-1:0];
            if (head_q == Empty) state <= S_POP;
            else state <= S_SCANW;
          end else if (next_q == Empty) begin
            state <= S_POP;
          end else begin
            slot <= next_q; state <= S_SCANW;
          end
        end
        S_SCANW: state <= S_SLOTW;
        S_SLOTW: state <= S_MARK;
        S_MARK: begin
          if (!dist_q[NW] && tgt_q <= LastNode && wr_cnt < (NW+1)'(tdb_pkg::MaxNodes)) begin
            wr_ptr <= wr_ptr + NW'(1); wr_cnt <= wr_cnt + (NW+1)'(1);
          end
          if (next_q == Empty) state <= S_POP;
          else begin
            slot <= next_q; state <= S_SCANW;
          end
        end
        S_SCAN: begin
          // dist_q of cnt-1 arrives; pipeline by one
          if (cnt > NW'(1) && dist_q[NW-1:0] > best) begin
            best <= dist_q[NW-1:0]; far <= cnt - NW'(1);
          end
          if (cnt > lim || lim == '0) state <= S_DONE;
          else cnt <= cnt + NW'(1);
        end
        S_DONE: begin
          if (!pass2) begin
            pass2 <= 1'b1; cur <= far; cnt <= '0; state <= S_MCLR;
          end else begin
            diameter <= best;
            done <= 1'b1; result_kind <= tdb_pkg::KindDiameter;
            result_value <= {{(21-NW){1'b0}}, best};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHECK_NEXT(a_start_busy, start && !busy && mode != tdb_pkg::ModeAdd, busy, "item not taken")
  `CHECK_ALWAYS(a_done_busy, !done || state == S_IDLE || state == S_INIT, "done while working")
  `CHECK_ALWAYS(a_edges_fit, edge_total <= Empty, "edge store overrun")
endmodule
`default_nettype wire

// ===== hw/rtl/tdb_query.sv =====
`default_nettype none
// query answer, registered: x-1 up to diameter+1 (0 for x of 0), then 2*(x-diameter-1)+diameter
module tdb_query (
  input  wire logic                     clk,
  input  wire logic [tdb_pkg::ValW-1:0] visit_count,
  input  wire logic [tdb_pkg::NodeW-1:0] diameter,
  output logic      [tdb_pkg::ValW-1:0] answer
);
  logic [tdb_pkg::ValW+1:0] d1;
  logic [tdb_pkg::ValW+1:0] x;
  logic [tdb_pkg::ValW+1:0] r;

  always_comb begin
    d1 = {{(tdb_pkg::ValW+1-tdb_pkg::NodeW){1'b0}}, diameter} + 23'd1;
    x = {2'b00, visit_count};
    if (x <= d1) begin
      r = (x == '0) ? '0 : x - 23'd1;
    end else begin
      r = ((x - d1) << 1) + d1 - 23'd1;
    end
  end

  // saturate to the output width
  always_ff @(posedge clk) begin
    answer <= (r[tdb_pkg::ValW+1:tdb_pkg::ValW] != 2'b00) ? {tdb_pkg::ValW{1'b1}}
                                                          : r[tdb_pkg::ValW-1:0];
  end
endmodule
`default_nettype wire
